/* rtl/ctps_pkg.sv */
// ----------------------------------------------------------------------------
// ctps_pkg: shared types and constants of the cursor triangle pick block
// Opcodes, event kinds, register indexes and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package ctps_pkg;

    localparam int VTX_W     = 32;
    localparam int DEN_W     = 32;
    localparam int WIN_W     = 13;
    localparam int NDC_BITS  = 20;
    localparam int QUOT_BITS = 28;
    localparam int EDGE_W    = QUOT_BITS + 1;
    localparam int PROD_W    = 2 * EDGE_W;

    localparam logic [2:0] OP_MOVE_BEGIN   = 3'd0;
    localparam logic [2:0] OP_TRIANGLE     = 3'd1;
    localparam logic [2:0] OP_MOVE_END     = 3'd2;
    localparam logic [2:0] OP_CLICK        = 3'd3;
    localparam logic [2:0] OP_EXT_SELECT   = 3'd4;
    localparam logic [2:0] OP_EXT_DESELECT = 3'd5;

    localparam logic [1:0] EV_HOVER    = 2'd0;
    localparam logic [1:0] EV_SELECT   = 2'd1;
    localparam logic [1:0] EV_DESELECT = 2'd2;

    localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [WIN_W-1:0] WIN_WIDTH_RESET  = 13'd1024;
    localparam logic [WIN_W-1:0] WIN_HEIGHT_RESET = 13'd768;

    // Last step index of the division and multiply sequences.
    localparam logic [2:0] STEP_LAST_MOVE = 3'd1;
    localparam logic [2:0] STEP_LAST_TRI  = 3'd5;

    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       div_store;
        logic       mul_en;
        logic       edge_eval;
        logic       event_go;
        logic [2:0] sel;
    } ctps_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctps_sts_t;

endpackage

/* rtl/ctps_div.sv */
// ----------------------------------------------------------------------------
// ctps_div: iterative signed divider
// Restoring division of magnitudes, one quotient bit per cycle, followed by
// a final step that applies the sign with truncation or floor rounding.
// ----------------------------------------------------------------------------
module ctps_div #(
    parameter int NW = 49
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [NW-1:0]                       num_mag,
    input  logic [ctps_pkg::DEN_W-1:0]          den_mag,
    input  logic                                neg,
    input  logic                                floor_mode,
    output logic                                done,
    output logic signed [NW:0]                  quot
);

    localparam int CW = $clog2(NW + 1);
    localparam int DW = ctps_pkg::DEN_W;

    logic [DW:0]      rem_reg, rem_next;
    logic [NW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    den_reg;
    logic             neg_reg, floor_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, fix_reg, done_reg;
    logic signed [NW:0] quot_reg;
    logic [DW:0]      rem_sh;
    logic             take;
    logic             round_down;

    always_comb begin
        rem_sh   = {rem_reg[DW-1:0], quo_reg[NW-1]};
        take     = rem_sh >= {1'b0, den_reg};
        rem_next = take ? rem_sh - {1'b0, den_reg} : rem_sh;
        quo_next = {quo_reg[NW-2:0], take};
        // Floor rounding of a negative inexact quotient gives -(q+1), which is ~q.
        round_down = floor_reg && (rem_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                fix_reg  <= 1'b1;
            end else if (fix_reg) begin
                fix_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= '0;
            quo_reg   <= num_mag;
            den_reg   <= den_mag;
            neg_reg   <= neg;
            floor_reg <= floor_mode;
            cnt_reg   <= CW'(NW);
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (fix_reg) begin
            if (neg_reg) begin
                quot_reg <= $signed(~{1'b0, quo_reg} + {{NW{1'b0}}, !round_down});
            end else begin
                quot_reg <= $signed({1'b0, quo_reg});
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/ctps_dp.sv */
// ----------------------------------------------------------------------------
// ctps_dp: datapath of the cursor triangle pick block
// Operand registers, the shared divider, one shared multiplier for the
// edge functions, the pick and selection state and the event register.
// ----------------------------------------------------------------------------
module ctps_dp #(
    parameter int ID_BITS         = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ctps_pkg::ctps_cmd_t                 cmd,
    output ctps_pkg::ctps_sts_t                 sts,
    input  logic                                cfg_valid,
    input  logic [1:0]                          cfg_index,
    input  logic [ctps_pkg::WIN_W-1:0]          cfg_data,
    input  logic [2:0]                          s_opcode,
    input  logic [15:0]                         s_object_id,
    input  logic signed [31:0]                  s_vertex_a_x,
    input  logic signed [31:0]                  s_vertex_a_y,
    input  logic signed [31:0]                  s_vertex_a_z,
    input  logic signed [31:0]                  s_vertex_b_x,
    input  logic signed [31:0]                  s_vertex_b_y,
    input  logic signed [31:0]                  s_vertex_b_z,
    input  logic signed [31:0]                  s_vertex_c_x,
    input  logic signed [31:0]                  s_vertex_c_y,
    input  logic signed [31:0]                  s_vertex_c_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_event_kind,
    output logic [15:0]                         m_event_id,
    output logic                                m_event_id_valid
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int NW  = ctps_pkg::VTX_W + 1 + F;
    localparam int QW  = NW + 1;
    localparam int TW  = QW + 1;
    localparam int NB  = ctps_pkg::NDC_BITS;
    localparam int QB  = ctps_pkg::QUOT_BITS;
    localparam int EW  = ctps_pkg::EDGE_W;
    localparam int PW  = ctps_pkg::PROD_W;
    localparam int WW  = ctps_pkg::WIN_W;

    logic [WW-1:0]        win_w_reg, win_h_reg;
    logic [2:0]           op_reg;
    logic [ID_BITS-1:0]   oid_reg;
    logic signed [31:0]   vx_reg [3];
    logic signed [31:0]   vy_reg [3];
    logic signed [31:0]   vz_reg [3];
    logic signed [QB-1:0] q_reg [6];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [NB-1:0] ndc_x_reg, ndc_y_reg;
    logic [ID_BITS-1:0]   cand_id_reg, hov_id_reg, sel_id_reg;
    logic                 cand_v_reg, hov_v_reg, sel_v_reg;
    logic                 m_valid_reg;
    logic [1:0]           m_kind_reg;
    logic [15:0]          m_id_reg;
    logic                 m_idv_reg;

    // Divider operand selection.
    logic                 is_move;
    logic signed [31:0]   dv, dz;
    logic [31:0]          dv_mag;
    logic [WW-1:0]        win, win1;
    logic [NW-1:0]        num_mag;
    logic [31:0]          den_mag;
    logic                 dneg;
    logic                 div_done;
    logic signed [QW-1:0] div_quot;

    always_comb begin
        is_move = op_reg == ctps_pkg::OP_MOVE_BEGIN;
        unique case (cmd.sel[2:1])
            2'd0: begin
                dv = cmd.sel[0] ? vy_reg[0] : vx_reg[0];
                dz = vz_reg[0];
            end
            2'd1: begin
                dv = cmd.sel[0] ? vy_reg[1] : vx_reg[1];
                dz = vz_reg[1];
            end
            default: begin
                dv = cmd.sel[0] ? vy_reg[2] : vx_reg[2];
                dz = vz_reg[2];
            end
        endcase
        dv_mag = dv[31] ? 32'(-dv) : 32'(dv);
        win    = cmd.sel[0] ? win_h_reg : win_w_reg;
        win1   = (win == '0) ? WW'(1) : win;
        if (is_move) begin
            // Cursor: 2 * p * one over the window size, floored.
            num_mag = {dv_mag, {(F + 1){1'b0}}};
            den_mag = {{(32 - WW){1'b0}}, win1};
            dneg    = dv[31];
        end else begin
            num_mag = {1'b0, dv_mag, {F{1'b0}}};
            den_mag = dz[31] ? 32'(-dz) : 32'(dz);
            dneg    = dv[31] ^ dz[31];
        end
    end

    ctps_div #(.NW(NW)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.div_start),
        .num_mag    (num_mag),
        .den_mag    (den_mag),
        .neg        (dneg),
        .floor_mode (is_move),
        .done       (div_done),
        .quot       (div_quot)
    );

    // Saturation of the quotient and of the cursor coordinates.
    logic signed [TW-1:0] one_fx, q_ext, t_x, t_y;
    logic signed [QB-1:0] q_sat;
    logic signed [NB-1:0] x_sat, y_sat;

    always_comb begin
        one_fx = {{(TW - F - 1){1'b0}}, 1'b1, {F{1'b0}}};
        q_ext  = {div_quot[QW-1], div_quot};
        t_x    = q_ext - one_fx;
        t_y    = one_fx - q_ext;
        if ((&div_quot[QW-1:QB-1]) || !(|div_quot[QW-1:QB-1])) begin
            q_sat = div_quot[QB-1:0];
        end else begin
            q_sat = {div_quot[QW-1], {(QB - 1){~div_quot[QW-1]}}};
        end
        if ((&t_x[TW-1:NB-1]) || !(|t_x[TW-1:NB-1])) begin
            x_sat = t_x[NB-1:0];
        end else begin
            x_sat = {t_x[TW-1], {(NB - 1){~t_x[TW-1]}}};
        end
        if ((&t_y[TW-1:NB-1]) || !(|t_y[TW-1:NB-1])) begin
            y_sat = t_y[NB-1:0];
        end else begin
            y_sat = {t_y[TW-1], {(NB - 1){~t_y[TW-1]}}};
        end
    end

    // Edge function operands. q_reg holds ax, ay, bx, by, cx, cy in that order.
    logic signed [EW-1:0] ndx_e, ndy_e, ma, mb;
    logic signed [EW-1:0] qe [6];

    always_comb begin
        ndx_e = EW'(ndc_x_reg);
        ndy_e = EW'(ndc_y_reg);
        for (int i = 0; i < 6; i++) begin
            qe[i] = EW'(q_reg[i]);
        end
        unique case (cmd.sel)
            3'd0: begin ma = ndx_e - qe[2]; mb = qe[1] - qe[3]; end
            3'd1: begin ma = qe[0] - qe[2]; mb = ndy_e - qe[3]; end
            3'd2: begin ma = ndx_e - qe[4]; mb = qe[3] - qe[5]; end
            3'd3: begin ma = qe[2] - qe[4]; mb = ndy_e - qe[5]; end
            3'd4: begin ma = ndx_e - qe[0]; mb = qe[5] - qe[1]; end
            default: begin ma = qe[4] - qe[0]; mb = ndy_e - qe[1]; end
        endcase
    end

    // Hit test: no edge value may be positive while another is negative, and no vertex z may be zero.
    logic any_pos, any_neg, zero_z, hit;

    always_comb begin
        any_pos = 1'b0;
        any_neg = 1'b0;
        for (int e = 0; e < 3; e++) begin
            any_pos = any_pos | (prod_reg[2*e] > prod_reg[2*e+1]);
            any_neg = any_neg | (prod_reg[2*e] < prod_reg[2*e+1]);
        end
        zero_z = (vz_reg[0] == '0) || (vz_reg[1] == '0) || (vz_reg[2] == '0);
        hit    = !(any_pos && any_neg) && !zero_z;
    end

    // Event decision for move end and left click.
    logic               same_hover, ev_emit;
    logic [1:0]         ev_kind;
    logic [ID_BITS-1:0] ev_id;
    logic               ev_idv;
    logic [ID_BITS-1:0] new_hov_id;

    always_comb begin
        same_hover = (cand_v_reg == hov_v_reg) &&
                     (!cand_v_reg || cand_id_reg == hov_id_reg);
        new_hov_id = cand_v_reg ? cand_id_reg : '0;
        ev_emit    = 1'b0;
        ev_kind    = ctps_pkg::EV_HOVER;
        ev_id      = '0;
        ev_idv     = 1'b0;
        if (op_reg == ctps_pkg::OP_MOVE_END) begin
            ev_emit = !same_hover && !sel_v_reg;
            ev_kind = ctps_pkg::EV_HOVER;
            ev_id   = new_hov_id;
            ev_idv  = cand_v_reg;
        end else if (hov_v_reg) begin
            ev_emit = 1'b1;
            ev_idv  = 1'b1;
            ev_id   = hov_id_reg;
            ev_kind = (sel_v_reg && hov_id_reg == sel_id_reg) ?
                      ctps_pkg::EV_DESELECT : ctps_pkg::EV_SELECT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_w_reg   <= ctps_pkg::WIN_WIDTH_RESET;
            win_h_reg   <= ctps_pkg::WIN_HEIGHT_RESET;
            ndc_x_reg   <= '0;
            ndc_y_reg   <= '0;
            cand_id_reg <= '0;
            cand_v_reg  <= 1'b0;
            hov_id_reg  <= '0;
            hov_v_reg   <= 1'b0;
            sel_id_reg  <= '0;
            sel_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == ctps_pkg::CFG_IDX_WIDTH) begin
                win_w_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == ctps_pkg::CFG_IDX_HEIGHT) begin
                win_h_reg <= cfg_data;
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.load) begin
                unique case (s_opcode)
                    ctps_pkg::OP_MOVE_BEGIN: begin
                        cand_v_reg  <= 1'b0;
                        cand_id_reg <= '0;
                    end
                    ctps_pkg::OP_EXT_SELECT: begin
                        sel_v_reg  <= 1'b1;
                        sel_id_reg <= ID_BITS'(s_object_id);
                    end
                    ctps_pkg::OP_EXT_DESELECT: begin
                        sel_v_reg  <= 1'b0;
                        sel_id_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.div_store && is_move) begin
                if (cmd.sel[0]) begin
                    ndc_y_reg <= y_sat;
                end else begin
                    ndc_x_reg <= x_sat;
                end
            end
            if (cmd.edge_eval && hit) begin
                cand_v_reg  <= 1'b1;
                cand_id_reg <= oid_reg;
            end
            if (cmd.event_go) begin
                if (op_reg == ctps_pkg::OP_MOVE_END) begin
                    hov_v_reg  <= cand_v_reg;
                    hov_id_reg <= new_hov_id;
                end else if (hov_v_reg) begin
                    if (ev_kind == ctps_pkg::EV_DESELECT) begin
                        sel_v_reg  <= 1'b0;
                        sel_id_reg <= '0;
                    end else begin
                        sel_v_reg  <= 1'b1;
                        sel_id_reg <= hov_id_reg;
                    end
                end
                if (ev_emit) begin
                    m_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            oid_reg   <= ID_BITS'(s_object_id);
            vx_reg[0] <= s_vertex_a_x;
            vy_reg[0] <= s_vertex_a_y;
            vz_reg[0] <= s_vertex_a_z;
            vx_reg[1] <= s_vertex_b_x;
            vy_reg[1] <= s_vertex_b_y;
            vz_reg[1] <= s_vertex_b_z;
            vx_reg[2] <= s_vertex_c_x;
            vy_reg[2] <= s_vertex_c_y;
            vz_reg[2] <= s_vertex_c_z;
        end
        if (cmd.div_store && !is_move) begin
            q_reg[cmd.sel] <= q_sat;
        end
        if (cmd.mul_en) begin
            prod_reg[cmd.sel] <= ma * mb;
        end
        if (cmd.event_go && ev_emit) begin
            m_kind_reg <= ev_kind;
            m_id_reg   <= 16'(ev_id);
            m_idv_reg  <= ev_idv;
        end
    end

    assign sts.div_done     = div_done;
    assign sts.out_free     = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_event_kind     = m_kind_reg;
    assign m_event_id       = m_id_reg;
    assign m_event_id_valid = m_idv_reg;

endmodule

/* rtl/ctps_ctrl.sv */
// ----------------------------------------------------------------------------
// ctps_ctrl: sequencing state machine of the cursor triangle pick block
// Accepts items, steps the divisions and edge products, and issues the
// event update once the output register can take a beat.
// ----------------------------------------------------------------------------
module ctps_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_opcode,
    input  ctps_pkg::ctps_sts_t   sts,
    output ctps_pkg::ctps_cmd_t   cmd
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DIV_GO   = 6'b000010,
        ST_DIV_WAIT = 6'b000100,
        ST_MUL      = 6'b001000,
        ST_EVAL     = 6'b010000,
        ST_EVENT    = 6'b100000
    } ctps_state_t;

    ctps_state_t state_reg, state_next;
    logic [2:0]  k_reg, k_next;
    logic        move_reg, move_next;
    logic        div_last;

    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        move_next  = move_reg;
        cmd        = '0;
        cmd.sel    = k_reg;
        s_ready    = 1'b0;
        div_last   = move_reg ? (k_reg == ctps_pkg::STEP_LAST_MOVE)
                              : (k_reg == ctps_pkg::STEP_LAST_TRI);
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    k_next   = '0;
                    unique case (s_opcode)
                        ctps_pkg::OP_MOVE_BEGIN: begin
                            move_next  = 1'b1;
                            state_next = ST_DIV_GO;
                        end
                        ctps_pkg::OP_TRIANGLE: begin
                            move_next  = 1'b0;
                            state_next = ST_DIV_GO;
                        end
                        ctps_pkg::OP_MOVE_END, ctps_pkg::OP_CLICK: begin
                            state_next = ST_EVENT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.div_store = 1'b1;
                    if (div_last) begin
                        k_next     = '0;
                        state_next = move_reg ? ST_IDLE : ST_MUL;
                    end else begin
                        k_next     = k_reg + 3'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                if (k_reg == ctps_pkg::STEP_LAST_TRI) begin
                    k_next     = '0;
                    state_next = ST_EVAL;
                end else begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_EVAL: begin
                cmd.edge_eval = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_EVENT: begin
                if (sts.out_free) begin
                    cmd.event_go = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            move_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            move_reg  <= move_next;
        end
    end

    a_event_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.event_go |-> sts.out_free)
        else $error("event issued while the output register is full");

    a_div_done_awaited: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> state_reg == ST_DIV_WAIT)
        else $error("divider finished while not awaited");

    a_select_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && (s_opcode == ctps_pkg::OP_EXT_SELECT ||
                      s_opcode == ctps_pkg::OP_EXT_DESELECT)) |=> state_reg == ST_IDLE)
        else $error("external select did not complete in one cycle");

    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_store || cmd.mul_en) |-> k_reg <= ctps_pkg::STEP_LAST_TRI)
        else $error("step index out of range");

endmodule

/* rtl/cursor_triangle_pick_select_core.sv */
// ----------------------------------------------------------------------------
// cursor_triangle_pick_select_core: cursor picking and selection
// Point-in-triangle picking with perspective division and hover/selection
// tracking, producing hover, select and deselect events.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command beat at a time: move begin, triangle,
//   move end, left click, external select or external deselect. The m_
//   channel carries hover, select and deselect event beats; move end and
//   left click give at most one beat each, the other commands none.
//   The cfg channel writes the window width (index 0) and height (index 1);
//   it is always ready and must only be used while the block is idle.
// Sequencing:
//   triangle: six divisions on one shared bit-serial divider, each giving
//   33 + COORD_FRAC_BITS quotient bits, then six products on one multiplier
//   and one compare step; move begin: two divisions; the others use none.
// Reset clears the cursor, candidate, hover and selection state and loads
//   the window registers with 1024 by 768.
// A stalled m_ channel holds its event register; commands that emit no
//   event are still accepted, and the next event-producing command waits.
// ----------------------------------------------------------------------------
module cursor_triangle_pick_select_core #(
    parameter int ID_BITS         = 16,
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [12:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_opcode,
    input  logic [15:0]         s_object_id,
    input  logic signed [31:0]  s_vertex_a_x,
    input  logic signed [31:0]  s_vertex_a_y,
    input  logic signed [31:0]  s_vertex_a_z,
    input  logic signed [31:0]  s_vertex_b_x,
    input  logic signed [31:0]  s_vertex_b_y,
    input  logic signed [31:0]  s_vertex_b_z,
    input  logic signed [31:0]  s_vertex_c_x,
    input  logic signed [31:0]  s_vertex_c_y,
    input  logic signed [31:0]  s_vertex_c_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_event_kind,
    output logic [15:0]         m_event_id,
    output logic                m_event_id_valid
);

    ctps_pkg::ctps_cmd_t cmd;
    ctps_pkg::ctps_sts_t sts;

    assign cfg_ready = 1'b1;

    ctps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .sts      (sts),
        .cmd      (cmd)
    );

    ctps_dp #(
        .ID_BITS         (ID_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_opcode         (s_opcode),
        .s_object_id      (s_object_id),
        .s_vertex_a_x     (s_vertex_a_x),
        .s_vertex_a_y     (s_vertex_a_y),
        .s_vertex_a_z     (s_vertex_a_z),
        .s_vertex_b_x     (s_vertex_b_x),
        .s_vertex_b_y     (s_vertex_b_y),
        .s_vertex_b_z     (s_vertex_b_z),
        .s_vertex_c_x     (s_vertex_c_x),
        .s_vertex_c_y     (s_vertex_c_y),
        .s_vertex_c_z     (s_vertex_c_z),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_kind     (m_event_kind),
        .m_event_id       (m_event_id),
        .m_event_id_valid (m_event_id_valid)
    );

endmodule
